@@ sv/imuct_pkg.sv @@
// Shared types, constants and helper functions of the IMU tilt filter.
`default_nettype none
package imuct_pkg;

	// Calibration and CORDIC lengths
	localparam int CalSamples  = 10;
	localparam int CordicSteps = 20;
	localparam int CordicIters = (CordicSteps < 32) ? CordicSteps : 32;

	// Register indexes
	localparam logic RegBlend = 1'b0;
	localparam logic RegSens  = 1'b1;

	// Numeric constants
	localparam logic [16:0]        WeightOne = 17'd65536;
	localparam logic [15:0]        SensScale = 16'd25;
	localparam logic signed [31:0] Deg90Q16  = 32'sd5898240;
	localparam logic [63:0]        IncLimit  = 64'h0000_0002_0000_0000;

	// Divider and sqrt iteration counts
	localparam int DivBits  = 64;
	localparam int SqrtBits = 32;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_BIAS_GO,
		ST_BIAS_WAIT,
		ST_SQ_A,
		ST_SQ_B,
		ST_SQ_C,
		ST_SQ_D,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_CD_GO,
		ST_CD_WAIT,
		ST_INC_LO,
		ST_INC_HI,
		ST_INC_SUM,
		ST_INC_WAIT,
		ST_BL_A,
		ST_BL_B,
		ST_BL_C,
		ST_DONE
	} state_t;

	// atan(2^-i) in degrees, Q16.16
	function automatic logic [21:0] atan_deg_q16(input logic [4:0] idx);
		logic [21:0] v;
		case (idx)
			5'd0:    v = 22'd2949120;
			5'd1:    v = 22'd1740967;
			5'd2:    v = 22'd919879;
			5'd3:    v = 22'd466945;
			5'd4:    v = 22'd234379;
			5'd5:    v = 22'd117304;
			5'd6:    v = 22'd58666;
			5'd7:    v = 22'd29335;
			5'd8:    v = 22'd14668;
			5'd9:    v = 22'd7334;
			5'd10:   v = 22'd3667;
			5'd11:   v = 22'd1833;
			5'd12:   v = 22'd917;
			5'd13:   v = 22'd458;
			5'd14:   v = 22'd229;
			5'd15:   v = 22'd115;
			5'd16:   v = 22'd57;
			5'd17:   v = 22'd29;
			5'd18:   v = 22'd14;
			5'd19:   v = 22'd7;
			5'd20:   v = 22'd4;
			5'd21:   v = 22'd2;
			5'd22:   v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

	// Clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
		logic signed [31:0] r;
		if (v > 40'sh007FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -40'sh0080000000)
			r = -32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage
`default_nettype wire

@@ sv/imu_complementary_tilt_filter_core.sv @@
// Top level of the IMU complementary tilt filter: sequencer, state and ports.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------
//  in      | input     | in_valid / in_stall   | accel_*_raw, gyro_*_raw, time_ms
//  out     | output    | out_valid / out_stall | fused_angle_*, drift_angle_*, ready_res
//  cfg     | APB       | psel/penable/pwrite   | paddr, pwdata, prdata, pready
//
// One item at a time; in_stall is high from acceptance until the result is
// loaded into the output register. Calibration items go straight to the
// output; the last calibration item runs three bias divides. A running item
// uses the 64-step divider, the 32-step square root and the 20-step CORDIC,
// all shared. Reset is asynchronous; no clearing pass. A stalled output holds
// the block.
`default_nettype none
module imu_complementary_tilt_filter_core
	import imuct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [15:0] accel_x_raw,
	input  wire logic signed [15:0] accel_y_raw,
	input  wire logic signed [15:0] accel_z_raw,
	input  wire logic signed [15:0] gyro_x_raw,
	input  wire logic signed [15:0] gyro_y_raw,
	input  wire logic signed [15:0] gyro_z_raw,
	input  wire logic [31:0]        time_ms,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      fused_angle_x,
	output logic signed [31:0]      fused_angle_y,
	output logic signed [31:0]      fused_angle_z,
	output logic signed [31:0]      drift_angle_x,
	output logic signed [31:0]      drift_angle_y,
	output logic signed [31:0]      drift_angle_z,
	output logic                    ready_res,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	localparam logic [4:0] CalLast = 5'(CalSamples);
	localparam logic [4:0] CalDone = 5'(CalSamples + 1);

	state_t state_q, state_d;

	// configuration
	logic [16:0] blend_q;
	logic [10:0] sens_q;

	// latched item
	logic signed [15:0] ax_q, ay_q, az_q;
	logic signed [15:0] g_q [3];
	logic [31:0]        t_q;

	// filter state
	logic [4:0]         calib_q;
	logic signed [23:0] sum_q  [3];
	logic signed [23:0] bias_q [3];
	logic [31:0]        prev_q;
	logic signed [31:0] filt_q  [3];
	logic signed [31:0] drift_q [3];

	// working registers
	logic [1:0]         axis_q;
	logic               tilt_q;
	logic [30:0]        sqa_q, sqb_q;
	logic [31:0]        sqx_q, sqy_q;
	logic signed [31:0] acc_q [2];
	logic [40:0]        plo_q;
	logic signed [53:0] wf_q;
	logic signed [35:0] f_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] fx_q, fy_q, fz_q, dx_q, dy_q, dz_q;
	logic               rdy_q;

	// unit hookups
	logic signed [35:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [53:0] mul_p;
	logic               div_start, div_busy;
	logic [63:0]        div_dvd, div_quo;
	logic [15:0]        div_dsr;
	logic               rt_start, rt_busy;
	logic [31:0]        rt_root;
	logic               cd_start, cd_busy;
	logic signed [35:0] cd_y0;
	logic signed [31:0] cd_angle;

	logic               in_acc;
	logic               out_load;
	logic               cfg_wr;

	// derived operands
	logic [16:0]        w_eff;
	logic [16:0]        w_inv;
	logic [10:0]        sens_eff;
	logic [15:0]        div_c;
	logic [31:0]        dt;
	logic signed [15:0] g_sel;
	logic signed [23:0] bias_sel;
	logic signed [24:0] diff;
	logic [24:0]        mag;
	logic signed [31:0] bsum;
	logic [31:0]        bmag;
	logic [57:0]        prod;
	logic [33:0]        qc;
	logic signed [34:0] d_inc;
	logic signed [35:0] f_new;
	logic signed [35:0] drift_new;
	logic signed [54:0] bl;
	logic signed [16:0] num17;
	logic signed [31:0] tilt_val;

	assign in_acc = in_valid && !in_stall;
	assign cfg_wr = psel && penable && pwrite && pready;

	assign w_eff    = (blend_q > WeightOne) ? WeightOne : blend_q;
	assign w_inv    = WeightOne - w_eff;
	assign sens_eff = (sens_q == 11'd0) ? 11'd1 : sens_q;
	assign div_c    = {5'd0, sens_eff} * SensScale;
	assign dt       = t_q - prev_q;

	// gyro increment magnitude
	assign g_sel    = g_q[axis_q];
	assign bias_sel = bias_q[axis_q];
	assign diff     = {g_sel[15], g_sel, 8'd0} - {bias_sel[23], bias_sel};
	assign mag      = diff[24] ? 25'(-diff) : 25'(diff);

	// bias numerator
	assign bsum = {sum_q[axis_q], 8'd0};
	assign bmag = bsum[31] ? 32'(-bsum) : 32'(bsum);

	// mag * dt from two partial products, then limit
	assign prod  = {17'd0, plo_q} + {1'b0, mul_p[40:0], 16'd0};
	assign qc    = (div_quo > IncLimit) ? IncLimit[33:0] : div_quo[33:0];
	assign d_inc = diff[24] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
	assign f_new     = 36'(filt_q[axis_q]) + 36'(d_inc);
	assign drift_new = 36'(drift_q[axis_q]) + 36'(d_inc);

	// blend sum
	assign bl = 55'(wf_q) + 55'(mul_p) + 55'sd32768;

	// tilt numerator and special cases
	assign num17    = tilt_q ? -17'(ax_q) : 17'(ay_q);
	assign cd_y0    = 36'($signed({num17, 16'd0}));
	assign tilt_val = (num17 == 17'sd0) ? 32'sd0 :
		(rt_root == 32'd0) ? (num17[16] ? -Deg90Q16 : Deg90Q16) : cd_angle;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (calib_q == CalLast)
						state_d = ST_BIAS_GO;
					else if (calib_q == CalDone)
						state_d = ST_SQ_A;
					else
						state_d = ST_DONE;
				end
			end
			ST_BIAS_GO:   state_d = ST_BIAS_WAIT;
			ST_BIAS_WAIT: begin
				if (!div_busy)
					state_d = (axis_q == 2'd2) ? ST_DONE : ST_BIAS_GO;
			end
			ST_SQ_A:    state_d = ST_SQ_B;
			ST_SQ_B:    state_d = ST_SQ_C;
			ST_SQ_C:    state_d = ST_SQ_D;
			ST_SQ_D:    state_d = ST_RT_GO;
			ST_RT_GO:   state_d = ST_RT_WAIT;
			ST_RT_WAIT: if (!rt_busy) state_d = ST_CD_GO;
			ST_CD_GO:   state_d = ST_CD_WAIT;
			ST_CD_WAIT: begin
				if (!cd_busy)
					state_d = tilt_q ? ST_INC_LO : ST_RT_GO;
			end
			ST_INC_LO:   state_d = ST_INC_HI;
			ST_INC_HI:   state_d = ST_INC_SUM;
			ST_INC_SUM:  state_d = ST_INC_WAIT;
			ST_INC_WAIT: begin
				if (!div_busy)
					state_d = (axis_q == 2'd2) ? ST_DONE : ST_BL_A;
			end
			ST_BL_A: state_d = ST_BL_B;
			ST_BL_B: state_d = ST_BL_C;
			ST_BL_C: state_d = ST_INC_LO;
			ST_DONE: if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		div_start = (state_q == ST_BIAS_GO) || (state_q == ST_INC_SUM);
		rt_start  = (state_q == ST_RT_GO);
		cd_start  = (state_q == ST_CD_GO);
		out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
		div_dvd   = {prod, 6'd0} + {49'd0, div_c[15:1]};
		div_dsr   = div_c;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			ST_BIAS_GO: begin
				div_dvd = {32'd0, bmag} + 64'(CalSamples / 2);
				div_dsr = 16'(CalSamples);
			end
			ST_SQ_A: begin
				mul_a = 36'(ax_q);
				mul_b = 18'(ax_q);
			end
			ST_SQ_B: begin
				mul_a = 36'(ay_q);
				mul_b = 18'(ay_q);
			end
			ST_SQ_C: begin
				mul_a = 36'(az_q);
				mul_b = 18'(az_q);
			end
			ST_INC_LO: begin
				mul_a = $signed({11'd0, mag});
				mul_b = $signed({2'b00, dt[15:0]});
			end
			ST_INC_HI: begin
				mul_a = $signed({11'd0, mag});
				mul_b = $signed({2'b00, dt[31:16]});
			end
			ST_BL_A: begin
				mul_a = f_q;
				mul_b = $signed({1'b0, w_eff});
			end
			ST_BL_B: begin
				mul_a = 36'(acc_q[axis_q[0]]);
				mul_b = $signed({1'b0, w_inv});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_q <= 17'd62915;
			sens_q  <= 11'd1310;
		end else if (cfg_wr) begin
			if (paddr[2] == RegBlend)
				blend_q <= pwdata[16:0];
			else
				sens_q <= pwdata[10:0];
		end
	end

	assign prdata = (paddr[2] == RegSens) ? {21'd0, sens_q} : {15'd0, blend_q};
	assign pready = 1'b1;

	// filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_q <= '0;
			prev_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				sum_q[i]   <= '0;
				bias_q[i]  <= '0;
				filt_q[i]  <= '0;
				drift_q[i] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && calib_q != CalDone) begin
						calib_q <= calib_q + 5'd1;
						if (calib_q != 5'd0) begin
							sum_q[0] <= sum_q[0] + 24'(gyro_x_raw);
							sum_q[1] <= sum_q[1] + 24'(gyro_y_raw);
							sum_q[2] <= sum_q[2] + 24'(gyro_z_raw);
						end
						if (calib_q == CalLast) begin
							prev_q <= time_ms;
							for (int i = 0; i < 3; i++) begin
								filt_q[i]  <= '0;
								drift_q[i] <= '0;
							end
						end
					end
				end
				ST_BIAS_WAIT: begin
					if (!div_busy)
						bias_q[axis_q] <= bsum[31] ? -24'(div_quo) : 24'(div_quo);
				end
				ST_INC_WAIT: begin
					if (!div_busy) begin
						drift_q[axis_q] <= sat32(40'(drift_new));
						if (axis_q == 2'd2) begin
							filt_q[2] <= sat32(40'(f_new));
							prev_q    <= t_q;
						end
					end
				end
				ST_BL_C: filt_q[axis_q] <= sat32(40'($signed(bl[54:16])));
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				ax_q   <= accel_x_raw;
				ay_q   <= accel_y_raw;
				az_q   <= accel_z_raw;
				g_q[0] <= gyro_x_raw;
				g_q[1] <= gyro_y_raw;
				g_q[2] <= gyro_z_raw;
				t_q    <= time_ms;
				axis_q <= 2'd0;
				tilt_q <= 1'b0;
			end
			ST_BIAS_WAIT: if (!div_busy) axis_q <= axis_q + 2'd1;
			ST_SQ_B: sqa_q <= mul_p[30:0];
			ST_SQ_C: sqb_q <= mul_p[30:0];
			ST_SQ_D: begin
				sqx_q <= {1'b0, sqa_q} + {1'b0, mul_p[30:0]};
				sqy_q <= {1'b0, sqb_q} + {1'b0, mul_p[30:0]};
			end
			ST_CD_WAIT: begin
				if (!cd_busy) begin
					acc_q[tilt_q] <= tilt_val;
					tilt_q        <= 1'b1;
					axis_q        <= 2'd0;
				end
			end
			ST_INC_HI: plo_q <= mul_p[40:0];
			ST_INC_WAIT: if (!div_busy) f_q <= f_new;
			ST_BL_B: wf_q <= mul_p;
			ST_BL_C: axis_q <= axis_q + 2'd1;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			fx_q  <= filt_q[0];
			fy_q  <= filt_q[1];
			fz_q  <= filt_q[2];
			dx_q  <= drift_q[0];
			dy_q  <= drift_q[1];
			dz_q  <= drift_q[2];
			rdy_q <= (calib_q == CalDone);
		end
	end

	assign out_valid     = out_valid_q;
	assign fused_angle_x = fx_q;
	assign fused_angle_y = fy_q;
	assign fused_angle_z = fz_q;
	assign drift_angle_x = dx_q;
	assign drift_angle_y = dy_q;
	assign drift_angle_z = dz_q;
	assign ready_res     = rdy_q;

	// shared units
	imuct_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	imuct_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	imuct_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rt_start),
		.radicand (tilt_q ? sqy_q : sqx_q),
		.busy     (rt_busy),
		.root     (rt_root)
	);

	imuct_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.x0     ($signed({4'd0, rt_root})),
		.y0     (cd_y0),
		.busy   (cd_busy),
		.angle  (cd_angle)
	);

	// checks
	a_unit_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({div_busy, rt_busy, cd_busy}))
		else $error("more than one shared unit busy");

	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider restarted while busy");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("item accepted but sequencer stayed idle");

	a_ready_after_cal: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && calib_q != CalDone |-> filt_q[0] == 32'sd0 && drift_q[2] == 32'sd0)
		else $error("angles moved during calibration");

endmodule
`default_nettype wire

@@ sv/imuct_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none
module imuct_mul
	import imuct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic signed [35:0] a,
	input  wire logic signed [17:0] b,
	output logic signed [53:0]      p
);

	// product register
	always_ff @(posedge clk) begin
		p <= a * b;
	end

endmodule
`default_nettype wire

@@ sv/imuct_div.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module imuct_div
	import imuct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [15:0] divisor,
	output logic             busy,
	output logic [63:0]      quotient
);

	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [63:0] dvd_q;
	logic [15:0] rem_q;
	logic [15:0] dsr_q;
	logic [16:0] rem_sh;
	logic        ge;

	// trial subtract
	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 6'(DivBits - 1);
		end else if (busy_q) begin
			if (cnt_q == 6'd0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 6'd1;
		end
	end

	// datapath: dividend shifts out, quotient shifts in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[62:0], ge};
			rem_q <= ge ? 16'(rem_sh - {1'b0, dsr_q}) : rem_sh[15:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = dvd_q;

endmodule
`default_nettype wire

@@ sv/imuct_sqrt.sv @@
// Digit-by-digit integer square root of radicand * 2^32, two bits per cycle.
`default_nettype none
module imuct_sqrt
	import imuct_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] radicand,
	output logic             busy,
	output logic [31:0]      root
);

	logic [4:0]  cnt_q;
	logic        busy_q;
	logic [63:0] v_q;
	logic [33:0] rem_q;
	logic [31:0] root_q;
	logic [35:0] rem_sh;
	logic [35:0] trial;
	logic        ge;

	assign rem_sh = {rem_q, v_q[63:62]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= 5'(SqrtBits - 1);
		end else if (busy_q) begin
			if (cnt_q == 5'd0)
				busy_q <= 1'b0;
			else
				cnt_q <= cnt_q - 5'd1;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= {radicand, 32'd0};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[61:0], 2'b00};
			rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
			root_q <= {root_q[30:0], ge};
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule
`default_nettype wire

@@ sv/imuct_cordic.sv @@
// Vectoring CORDIC: angle of (x, y) in Q16.16 degrees, one rotation per cycle.
`default_nettype none
module imuct_cordic
	import imuct_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [35:0] x0,
	input  wire logic signed [35:0] y0,
	output logic                    busy,
	output logic signed [31:0]      angle
);

	logic               busy_q;
	logic [4:0]         i_q;
	logic signed [35:0] x_q;
	logic signed [35:0] y_q;
	logic signed [31:0] z_q;
	logic signed [35:0] xs;
	logic signed [35:0] ys;
	logic signed [31:0] step;

	assign xs   = x_q >>> i_q;
	assign ys   = y_q >>> i_q;
	assign step = $signed({10'd0, atan_deg_q16(i_q)});

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == 5'(CordicIters - 1))
				busy_q <= 1'b0;
			else
				i_q <= i_q + 5'd1;
		end
	end

	// rotate toward y = 0
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= '0;
		end else if (busy_q) begin
			if (!y_q[35]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + step;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - step;
			end
		end
	end

	assign busy  = busy_q;
	assign angle = z_q;

endmodule
`default_nettype wire
